[rtl/b75dec_pkg.sv]
// Shared types, constants and the symbol-to-digit map of the base-75 block decoder.
// No dependencies; used by b75dec_emitter and base75_block_decoder_unit.
`default_nettype none

package b75dec_pkg;

   localparam int SymbolsPerBlock = 9;
   localparam int BytesPerBlock   = 7;

   localparam int DigitWidth  = 7;
   localparam int AccWidth    = 57;
   localparam int WeightWidth = 50;
   localparam int BlockBits   = 8 * BytesPerBlock;
   localparam int CountWidth  = $clog2(SymbolsPerBlock + 1);
   localparam int IndexWidth  = $clog2(BytesPerBlock + 1);

   localparam logic [WeightWidth-1:0] DigitBase = WeightWidth'(75);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SYMBOL = 2'd1,
      STATUS_TOO_LARGE  = 2'd2
   } status_type;

   typedef struct packed {
      logic                  ok;
      logic [DigitWidth-1:0] value;
   } digit_type;

   typedef struct packed {
      logic                 load;
      logic [BlockBits-1:0] value;
      status_type           status;
      logic                 stream_end;
   } emit_type;

   function automatic digit_type digit_of(input logic [7:0] sym);
      digit_type d;
      d.ok    = 1'b1;
      d.value = '0;
      case (sym) inside
         8'h21: d.value = DigitWidth'(0);
         8'h24: d.value = DigitWidth'(1);
         8'h2b: d.value = DigitWidth'(2);
         8'h2c: d.value = DigitWidth'(3);
         8'h2d: d.value = DigitWidth'(4);
         8'h5b: d.value = DigitWidth'(5);
         8'h5d: d.value = DigitWidth'(6);
         [8'h30:8'h39]: d.value = DigitWidth'(sym - 8'h30) + DigitWidth'(7);
         8'h3a: d.value = DigitWidth'(17);
         8'h3d: d.value = DigitWidth'(18);
         8'h3f: d.value = DigitWidth'(19);
         8'h40: d.value = DigitWidth'(20);
         [8'h41:8'h5a]: d.value = DigitWidth'(sym - 8'h41) + DigitWidth'(21);
         8'h5f: d.value = DigitWidth'(47);
         [8'h61:8'h7a]: d.value = DigitWidth'(sym - 8'h61) + DigitWidth'(48);
         8'h7e: d.value = DigitWidth'(74);
         default: d.ok = 1'b0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/b75dec_emitter.sv]
// Result register of the base-75 block decoder: sends a decoded block one byte per transfer.
// Depends on b75dec_pkg.
`default_nettype none

module b75dec_emitter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b75dec_pkg::emit_type  emit,
   output logic                       ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_data_byte,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_run_last,
   output logic                       rsp_stream_last
);

   logic                                 valid_ff;
   logic [b75dec_pkg::BlockBits-1:0]     data_ff;
   b75dec_pkg::status_type               status_ff;
   logic                                 end_ff;
   logic [b75dec_pkg::IndexWidth-1:0]    index_ff;
   logic                                 last;

   assign last = (status_ff != b75dec_pkg::STATUS_OK)
              || (index_ff == b75dec_pkg::IndexWidth'(b75dec_pkg::BytesPerBlock - 1));
   assign ready = !valid_ff || (last && !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else if (emit.load) begin
         valid_ff <= 1'b1;
         index_ff <= '0;
      end else if (valid_ff && !rsp_stall) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            index_ff <= index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load) begin
         data_ff   <= emit.value;
         status_ff <= emit.status;
         end_ff    <= emit.stream_end;
      end else if (valid_ff && !rsp_stall) begin
         data_ff <= data_ff >> 8;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_byte   = data_ff[7:0];
   assign rsp_status      = status_ff;
   assign rsp_run_last    = last;
   assign rsp_stream_last = last && end_ff;

endmodule

`default_nettype wire

[rtl/base75_block_decoder_unit.sv]
// Top level of the base-75 block decoder: input register, digit accumulation, result emitter.
// Depends on b75dec_pkg and b75dec_emitter.
//
// Use: one symbol byte per transfer on req_ (req_end_of_stream on the final symbol).
// Every 9 valid symbols, or the end of the stream, give 7 result transfers on rsp_,
// least significant byte first, run_last on the seventh. An invalid symbol or a block
// value of 2^56 or more gives one error transfer (status 1 or 2, byte 0, both last
// flags set); symbols up to and including the next end-of-stream are then dropped.
// A symbol is folded in as it leaves the input register, which also loads any result it
// produces into the emitter. Throughput: one symbol per cycle while req_stall is low; one
// result per cycle from the byte emitter, which holds one block, while rsp_stall is low.
// A symbol completing a block waits in the input register while the emitter still sends the
// previous one; without receiver stalls, that ends before 9 further symbols fill another block.
// Reset clears the partial block, the drop flag and both valid registers.
// When the receiver stalls, the current result holds and, once the input register
// is waiting on the emitter, req_stall rises.
`default_nettype none

module base75_block_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_end_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_run_last,
   output logic            rsp_stream_last
);

   logic                                    in_valid_ff;
   logic [7:0]                              in_symbol_ff;
   logic                                    in_eos_ff;

   logic [b75dec_pkg::AccWidth-1:0]         acc_ff;
   logic [b75dec_pkg::WeightWidth-1:0]      weight_ff;
   logic [b75dec_pkg::CountWidth-1:0]       count_ff;
   logic                                    drop_ff;

   b75dec_pkg::digit_type                   digit;
   logic [b75dec_pkg::AccWidth-1:0]         product;
   logic [b75dec_pkg::AccWidth-1:0]         acc_in;
   logic [b75dec_pkg::CountWidth-1:0]       count_in;
   logic                                    block_done;
   logic                                    too_large;
   logic                                    produces;
   logic                                    advance;
   logic                                    emit_ready;
   b75dec_pkg::emit_type                    emit;

   assign digit      = b75dec_pkg::digit_of(in_symbol_ff);
   assign product    = b75dec_pkg::AccWidth'(weight_ff) * b75dec_pkg::AccWidth'(digit.value);
   assign acc_in     = acc_ff + product;
   assign count_in   = count_ff + 1'b1;
   assign block_done = (count_in == b75dec_pkg::CountWidth'(b75dec_pkg::SymbolsPerBlock))
                    || in_eos_ff;
   assign too_large  = |acc_in[b75dec_pkg::AccWidth-1:b75dec_pkg::BlockBits];
   assign produces   = !drop_ff && (!digit.ok || block_done);
   assign advance    = in_valid_ff && (!produces || emit_ready);
   assign req_stall  = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_symbol_ff <= req_symbol;
         in_eos_ff    <= req_end_of_stream;
      end
   end

   always_comb begin
      emit.load       = 1'b0;
      emit.value      = '0;
      emit.status     = b75dec_pkg::STATUS_OK;
      emit.stream_end = in_eos_ff;
      if (advance && !drop_ff) begin
         if (!digit.ok) begin
            emit.load       = 1'b1;
            emit.status     = b75dec_pkg::STATUS_BAD_SYMBOL;
            emit.stream_end = 1'b1;
         end else if (block_done) begin
            emit.load = 1'b1;
            if (too_large) begin
               emit.status     = b75dec_pkg::STATUS_TOO_LARGE;
               emit.stream_end = 1'b1;
            end else begin
               emit.value = acc_in[b75dec_pkg::BlockBits-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         weight_ff <= b75dec_pkg::WeightWidth'(1);
         count_ff  <= '0;
         drop_ff   <= 1'b0;
      end else if (advance) begin
         if (drop_ff) begin
            if (in_eos_ff) begin
               drop_ff   <= 1'b0;
               acc_ff    <= '0;
               weight_ff <= b75dec_pkg::WeightWidth'(1);
               count_ff  <= '0;
            end
         end else if (digit.ok && !block_done) begin
            acc_ff    <= acc_in;
            weight_ff <= weight_ff * b75dec_pkg::DigitBase;
            count_ff  <= count_in;
         end else begin
            // block emitted or error: start afresh
            acc_ff    <= '0;
            weight_ff <= b75dec_pkg::WeightWidth'(1);
            count_ff  <= '0;
            drop_ff   <= (!digit.ok || too_large) && !in_eos_ff;
         end
      end
   end

   b75dec_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .emit            (emit),
      .ready           (emit_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_status      (rsp_status),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_last (rsp_stream_last)
   );

endmodule

`default_nettype wire

[sim/b75dec_checker.sv]
// Checker for the base-75 block decoder: watches both channels, predicts the decoded bytes
// and compares every result transfer with the oldest prediction.
// Depends on b75dec_pkg for the status codes and block sizes.
`default_nettype none

module b75dec_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_end_of_stream,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_data_byte,
   input  wire logic [1:0] rsp_status,
   input  wire logic       rsp_run_last,
   input  wire logic       rsp_stream_last,
   output int              error_count,
   output int              bytes_pending
);

   localparam int Radix = 75;
   localparam logic [8*Radix-1:0] Alphabet =
      {"!$+,-[]0123456789:=?@ABCDEFGHIJKLMNOPQRSTUVWXYZ", "_", "abcdefghijklmnopqrstuvwxyz~"};

   typedef struct packed {
      logic [7:0]             data_byte;
      b75dec_pkg::status_type status;
      logic                   run_last;
      logic                   stream_last;
   } decoded_byte_type;

   decoded_byte_type decoded_bytes[$];

   logic [56:0] block_value;
   logic [49:0] place_weight;
   logic [3:0]  digit_count;
   logic        dropping;

   task automatic clear_block();
      block_value  = '0;
      place_weight = 50'd1;
      digit_count  = '0;
   endtask

   task automatic push_error(input b75dec_pkg::status_type code, input logic eos);
      decoded_bytes.push_back('{8'h00, code, 1'b1, 1'b1});
      clear_block();
      dropping = !eos;
   endtask

   task automatic decode_symbol(input logic [7:0] sym, input logic eos);
      int          digit;
      logic [63:0] wide;
      digit = -1;
      if (dropping) begin
         if (eos) begin
            dropping = 1'b0;
            clear_block();
         end
         return;
      end
      for (int i = 0; i < Radix; i++) begin
         if (Alphabet[8*(Radix-1-i) +: 8] == sym)
            digit = i;
      end
      if (digit < 0) begin
         push_error(b75dec_pkg::STATUS_BAD_SYMBOL, eos);
         return;
      end
      wide = {7'd0, block_value} + 64'(digit) * {14'd0, place_weight};
      block_value = wide[56:0];
      digit_count = digit_count + 4'd1;
      if (int'(digit_count) < b75dec_pkg::SymbolsPerBlock && !eos) begin
         wide = {14'd0, place_weight} * 64'(Radix);
         place_weight = wide[49:0];
         return;
      end
      if (block_value >= (57'd1 << (8 * b75dec_pkg::BytesPerBlock))) begin
         push_error(b75dec_pkg::STATUS_TOO_LARGE, eos);
         return;
      end
      for (int k = 0; k < b75dec_pkg::BytesPerBlock; k++) begin
         decoded_bytes.push_back('{block_value[8*k +: 8], b75dec_pkg::STATUS_OK,
                                   k == b75dec_pkg::BytesPerBlock - 1,
                                   (k == b75dec_pkg::BytesPerBlock - 1) && eos});
      end
      clear_block();
   endtask

   task automatic check_byte();
      decoded_byte_type want;
      if (decoded_bytes.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t unexpected result: byte %h status %0d run_last %b stream_last %b",
                     $time, rsp_data_byte, rsp_status, rsp_run_last, rsp_stream_last);
         return;
      end
      want = decoded_bytes.pop_front();
      if (rsp_data_byte !== want.data_byte || rsp_status !== want.status ||
          rsp_run_last !== want.run_last || rsp_stream_last !== want.stream_last) begin
         error_count++;
         if (error_count <= 10) begin
            $write("%0t mismatch: expected byte %h status %0d run_last %b stream_last %b, ",
                   $time, want.data_byte, want.status, want.run_last, want.stream_last);
            $display("got byte %h status %0d run_last %b stream_last %b",
                     rsp_data_byte, rsp_status, rsp_run_last, rsp_stream_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decoded_bytes.delete();
         clear_block();
         dropping = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_byte();
         if (req_valid && !req_stall)
            decode_symbol(req_symbol, req_end_of_stream);
      end
      bytes_pending = decoded_bytes.size();
   end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench top for base75_block_decoder_unit: drives directed and random symbol streams
// under several idle and stall patterns and gives the verdict.
// Depends on b75dec_pkg, base75_block_decoder_unit and b75dec_checker.
`default_nettype none

module tb_top;

   localparam int Radix       = 75;
   localparam int ItemTarget  = 210;
   localparam int TailCycles  = 32;
   localparam int CycleLimit  = 300000;
   localparam logic [8*Radix-1:0] Alphabet =
      {"!$+,-[]0123456789:=?@ABCDEFGHIJKLMNOPQRSTUVWXYZ", "_", "abcdefghijklmnopqrstuvwxyz~"};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_symbol;
   logic       req_end_of_stream;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_status;
   logic       rsp_run_last;
   logic       rsp_stream_last;

   int error_count;
   int bytes_pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int counted   = 0;
   int cycles    = 0;
   logic skipping = 1'b0;

   base75_block_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol       (req_symbol),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_last  (rsp_stream_last)
   );

   b75dec_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol       (req_symbol),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_last  (rsp_stream_last),
      .error_count      (error_count),
      .bytes_pending    (bytes_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] symbol_of(input int digit);
      return Alphabet[8*(Radix-1-digit) +: 8];
   endfunction

   function automatic logic is_symbol(input logic [7:0] sym);
      for (int i = 0; i < Radix; i++) begin
         if (symbol_of(i) == sym)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic send_symbol(input logic [7:0] sym, input logic eos);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_symbol        <= sym;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      if (!skipping)
         counted++;
      if (eos)
         skipping = 1'b0;
      else if (!is_symbol(sym))
         skipping = 1'b1;
   endtask

   task automatic send_block(input logic [56:0] value, input logic eos);
      logic [56:0] rest;
      rest = value;
      for (int i = 0; i < b75dec_pkg::SymbolsPerBlock; i++) begin
         send_symbol(symbol_of(int'(rest % Radix)),
                     eos && (i == b75dec_pkg::SymbolsPerBlock - 1));
         rest = rest / Radix;
      end
   endtask

   task automatic send_stream();
      int         n;
      int         kind;
      int         bad_at;
      logic [7:0] sym;
      n      = ($urandom_range(9) < 3) ? 9 * $urandom_range(1, 3) : $urandom_range(1, 30);
      kind   = $urandom_range(99);
      bad_at = (kind >= 75 && kind < 88) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < n; i++) begin
         if (kind >= 88)
            sym = 8'($urandom_range(255));
         else if (i == bad_at)
            do sym = 8'($urandom_range(255)); while (is_symbol(sym));
         else if (kind < 10)
            sym = symbol_of($urandom_range(70, Radix - 1));
         else
            sym = symbol_of($urandom_range(Radix - 1));
         send_symbol(sym, i == n - 1);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_symbol        <= 8'h00;
      req_end_of_stream <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_symbol(symbol_of(0), 1'b1);
      send_symbol(symbol_of(Radix - 1), 1'b1);
      send_block((57'd1 << 56) - 57'd1, 1'b1);
      send_block(57'd1 << 56, 1'b1);
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hff, 1'b0);
      send_symbol(symbol_of(Radix - 1), 1'b0);
      send_symbol(symbol_of(0), 1'b1);

      counted = 0;
      while (counted < ItemTarget) begin
         case (counted * 4 / ItemTarget)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 45;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 45;
            end
            default: begin
               idle_pct  = 22;
               stall_pct = 22;
            end
         endcase
         send_stream();
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (bytes_pending != 0);
      repeat (TailCycles) @(negedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/b75dec_pkg.sv
rtl/b75dec_emitter.sv
rtl/base75_block_decoder_unit.sv
sim/b75dec_checker.sv
sim/tb_top.sv
